@@ sv/lpht_pkg.sv @@
// Shared types, field widths and codes of the linear probing hash table.
package lpht_pkg;

  localparam int OP_W     = 2;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int ENTRY_W  = 11;

  // Request kinds; code 3 has no meaning and answers not found.
  localparam logic [OP_W-1:0] OP_PUT = 2'd0;
  localparam logic [OP_W-1:0] OP_GET = 2'd1;
  localparam logic [OP_W-1:0] OP_DEL = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } lpht_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  found_value;
    logic [ENTRY_W-1:0]  entry_total;
  } lpht_out_t;

  typedef enum logic [2:0] {
    LS_CLEAR,
    LS_IDLE,
    LS_HOME,
    LS_PROBE,
    LS_DEL_READ,
    LS_DEL_CHECK
  } lpht_state_t;

endpackage

@@ sv/linear_probing_hash_table_unit.sv @@
// Top level of the linear probing hash table: slot memory, probe sequencer, occupancy counter.
//
//   channel   ports                      direction  beat taken when
//   -------   ------------------------   ---------  ----------------------
//   request   start, busy, in_data       in         start high, busy low
//   result    out_strobe, out_data       out        out_strobe high
//
// A put or get finds its home slot, by mask when TABLE_SIZE is a power of two
// and by reciprocal multiply otherwise, then probes from it. A delete then
// reads and checks each cluster entry after the hole and, for each moved
// entry, runs a home slot calculation and a probe. Probing reads one slot per
// cycle from the single slot memory. After reset the block sweeps every slot
// to empty with busy high before it takes a beat. The result strobe lasts one
// cycle and cannot be held off.
module linear_probing_hash_table_unit
  import lpht_pkg::*;
#(
  parameter int TABLE_SIZE = 1024,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  lpht_in_t  in_data,
  output logic      out_strobe,
  output lpht_out_t out_data
);

  localparam int ADDR_W = $clog2(TABLE_SIZE);
  localparam int KW     = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int VW     = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int WORD_W = 1 + KW + VW;
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(TABLE_SIZE - 1);

  // Slot memory: {valid, key, value}.
  logic [WORD_W-1:0] mem [TABLE_SIZE];
  logic [WORD_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;

  logic              rd_valid;
  logic [KW-1:0]     rd_key;
  logic [VW-1:0]     rd_val;

  lpht_state_t       state_r, state_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [KW-1:0]     key_r, key_nxt;
  logic [VW-1:0]     val_r, val_nxt;
  logic              reins_r, reins_nxt;
  logic [ADDR_W-1:0] p_r, p_nxt;
  logic [ADDR_W-1:0] chk_r, chk_nxt;
  logic [ADDR_W-1:0] s_r, s_nxt;
  logic [ADDR_W-1:0] occ_r, occ_nxt;
  logic              out_valid_r, out_valid_nxt;
  lpht_out_t         out_r, out_nxt;

  logic              home_start;
  logic [KW-1:0]     home_key;
  logic              home_done;
  logic [ADDR_W-1:0] home_slot;
  logic              hit;

  function automatic logic [ADDR_W-1:0] step_slot(input logic [ADDR_W-1:0] a);
    if (a == LAST) begin
      return '0;
    end
    return a + 1'b1;
  endfunction

  lpht_home #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEY_W_USED (KW)
  ) u_home (
    .clk   (clk),
    .rst_n (rst_n),
    .start (home_start),
    .key   (home_key),
    .done  (home_done),
    .home  (home_slot)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_valid = rd_data_r[WORD_W-1];
  assign rd_key   = rd_data_r[VW +: KW];
  assign rd_val   = rd_data_r[0 +: VW];
  assign hit      = rd_valid && (rd_key == key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= LS_CLEAR;
      p_r         <= '0;
      occ_r       <= '0;
      reins_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      p_r         <= p_nxt;
      occ_r       <= occ_nxt;
      reins_r     <= reins_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    key_r <= key_nxt;
    val_r <= val_nxt;
    chk_r <= chk_nxt;
    s_r   <= s_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    reins_nxt     = reins_r;
    p_nxt         = p_r;
    chk_nxt       = chk_r;
    s_nxt         = s_r;
    occ_nxt       = occ_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rd_addr       = p_r;
    wr_en         = 1'b0;
    wr_addr       = chk_r;
    wr_data       = {1'b1, key_r, val_r};
    home_start    = 1'b0;
    home_key      = key_r;

    case (state_r)
      LS_CLEAR: begin
        // Sweep every slot to empty after reset.
        wr_en   = 1'b1;
        wr_addr = p_r;
        wr_data = '0;
        if (p_r == LAST) begin
          p_nxt     = '0;
          state_nxt = LS_IDLE;
        end else begin
          p_nxt = p_r + 1'b1;
        end
      end

      LS_IDLE: begin
        if (start) begin
          op_nxt    = in_data.op;
          key_nxt   = in_data.key[KW-1:0];
          val_nxt   = in_data.value[VW-1:0];
          reins_nxt = 1'b0;
          if (in_data.op inside {OP_PUT, OP_GET, OP_DEL}) begin
            home_start = 1'b1;
            home_key   = in_data.key[KW-1:0];
            state_nxt  = LS_HOME;
          end else begin
            // Undefined request: answer at once, touch nothing.
            out_valid_nxt       = 1'b1;
            out_nxt.status      = ST_NOT_FOUND;
            out_nxt.found_value = '0;
            out_nxt.entry_total = ENTRY_W'(occ_r);
          end
        end
      end

      LS_HOME: begin
        // Issue the home slot read as soon as the remainder lands.
        if (home_done) begin
          rd_addr   = home_slot;
          chk_nxt   = home_slot;
          p_nxt     = step_slot(home_slot);
          state_nxt = LS_PROBE;
        end
      end

      LS_PROBE: begin
        if (rd_valid && !hit) begin
          // Advance: read the next slot while checking this one.
          rd_addr = p_r;
          chk_nxt = p_r;
          p_nxt   = step_slot(p_r);
        end else if (reins_r) begin
          // Re-insert the moved entry into the first empty slot.
          wr_en     = 1'b1;
          s_nxt     = step_slot(s_r);
          state_nxt = LS_DEL_READ;
        end else begin
          out_nxt.found_value = '0;
          out_nxt.status      = ST_NOT_FOUND;
          out_valid_nxt       = 1'b1;
          state_nxt           = LS_IDLE;
          case (op_r)
            OP_PUT: begin
              if (hit) begin
                wr_en          = 1'b1;
                out_nxt.status = ST_UPDATED;
              end else if (occ_r == LAST) begin
                out_nxt.status = ST_FULL;
              end else begin
                wr_en          = 1'b1;
                occ_nxt        = occ_r + 1'b1;
                out_nxt.status = ST_INSERTED;
              end
            end
            OP_GET: begin
              if (hit) begin
                out_nxt.status      = ST_FOUND;
                out_nxt.found_value = VALUE_W'(rd_val);
              end
            end
            OP_DEL: begin
              if (hit) begin
                // Open the hole, then walk the rest of the cluster.
                wr_en         = 1'b1;
                wr_data       = '0;
                s_nxt         = step_slot(chk_r);
                out_valid_nxt = 1'b0;
                state_nxt     = LS_DEL_READ;
              end
            end
            default: begin
              out_nxt.status = ST_NOT_FOUND;
            end
          endcase
          out_nxt.entry_total = ENTRY_W'(occ_nxt);
        end
      end

      LS_DEL_READ: begin
        rd_addr   = s_r;
        state_nxt = LS_DEL_CHECK;
      end

      LS_DEL_CHECK: begin
        if (!rd_valid) begin
          // Cluster ends: the delete is complete.
          occ_nxt             = occ_r - 1'b1;
          out_valid_nxt       = 1'b1;
          out_nxt.status      = ST_DELETED;
          out_nxt.found_value = '0;
          out_nxt.entry_total = ENTRY_W'(occ_nxt);
          state_nxt           = LS_IDLE;
        end else begin
          // Lift the entry out and probe again from its home slot.
          wr_en      = 1'b1;
          wr_addr    = s_r;
          wr_data    = '0;
          key_nxt    = rd_key;
          val_nxt    = rd_val;
          reins_nxt  = 1'b1;
          home_start = 1'b1;
          home_key   = rd_key;
          state_nxt  = LS_HOME;
        end
      end

      default: begin
        state_nxt = LS_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != LS_IDLE);
  assign out_strobe = out_valid_r;
  assign out_data   = out_r;

`ifndef SYNTHESIS
  // At least one slot always stays empty.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= LAST)
    else $error("occupied count reached the table size");

  // The count moves only when a probe or a cluster walk resolves.
  a_occ_where: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_nxt != occ_r) |-> (state_r == LS_PROBE || state_r == LS_DEL_CHECK))
    else $error("occupied count changed outside a resolve step");

  // No slot write while idle.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r != LS_IDLE))
    else $error("slot memory written while idle");

  // The home unit answers only while the sequencer waits for it.
  a_home_done: assert property (@(posedge clk) disable iff (!rst_n)
    home_done |-> (state_r == LS_HOME))
    else $error("home slot arrived outside the home wait");

  // A result beat follows a request beat or a resolve step.
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(state_r) == LS_IDLE || $past(state_r) == LS_PROBE ||
                    $past(state_r) == LS_DEL_CHECK))
    else $error("result strobe without a source");
`endif

endmodule

@@ sv/lpht_home.sv @@
// Home slot unit: key modulo the table size, by bit mask when the size is a power of two, else by reciprocal multiply.
module lpht_home
  import lpht_pkg::*;
#(
  parameter int TABLE_SIZE = 1024,
  parameter int KEY_W_USED = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [KEY_W_USED-1:0]         key,
  output logic                          done,
  output logic [$clog2(TABLE_SIZE)-1:0] home
);

  localparam int ADDR_W  = $clog2(TABLE_SIZE);
  localparam bit IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

  generate
    if (IS_POW2) begin : g_mask
      localparam int EXT_W = (KEY_W_USED > ADDR_W) ? KEY_W_USED : ADDR_W;

      logic [EXT_W-1:0]  key_ext;
      logic              done_r;
      logic [ADDR_W-1:0] home_r;

      assign key_ext = EXT_W'(key);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          home_r <= key_ext[ADDR_W-1:0];
        end
      end

      assign done = done_r;
      assign home = home_r;
    end else begin : g_recip
      // Reciprocal multiply: (key * RECIP) >> SH is the exact quotient for
      // every key; the home slot is key minus quotient times table size.
      // Steps in order: latch, low partial product, quotient, remainder.
      localparam int          EXT_W    = (KEY_W_USED > ADDR_W) ? KEY_W_USED : ADDR_W;
      localparam int          SH       = KEY_W_USED + ADDR_W;
      localparam logic [63:0] RECIP    = ((64'd1 << SH) / 64'(TABLE_SIZE)) + 64'd1;
      localparam logic [15:0] RECIP_LO = RECIP[15:0];
      localparam logic [17:0] RECIP_HI = RECIP[33:16];
      localparam int          LO_W     = KEY_W_USED + 16;
      localparam int          HI_W     = KEY_W_USED + 18;
      localparam int          PW       = KEY_W_USED + 34;
      localparam int          QW       = PW - SH;
      localparam logic [ADDR_W-1:0] MOD_LO = ADDR_W'(TABLE_SIZE);

      logic [KEY_W_USED-1:0] key_r;
      logic [LO_W-1:0]       lo_r;
      logic [QW-1:0]         quot_r;
      logic [ADDR_W-1:0]     rem_r;
      logic [3:0]            ph_r;
      logic [LO_W-1:0]       lo_prod;
      logic [HI_W-1:0]       hi_prod;
      logic [PW-1:0]         full_prod;
      logic [EXT_W-1:0]      key_ext;
      logic [ADDR_W-1:0]     back;

      assign lo_prod   = LO_W'(key_r) * LO_W'(RECIP_LO);
      assign hi_prod   = HI_W'(key_r) * HI_W'(RECIP_HI);
      assign full_prod = PW'(lo_r) + {hi_prod, 16'b0};
      assign key_ext   = EXT_W'(key_r);
      // Only the low bits matter: the remainder is below the table size.
      assign back      = quot_r[ADDR_W-1:0] * MOD_LO;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          ph_r <= '0;
        end else begin
          ph_r <= {ph_r[2:0], start};
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          key_r <= key;
        end
        if (ph_r[0]) begin
          lo_r <= lo_prod;
        end
        if (ph_r[1]) begin
          quot_r <= full_prod[SH +: QW];
        end
        if (ph_r[2]) begin
          rem_r <= key_ext[ADDR_W-1:0] - back;
        end
      end

      assign done = ph_r[3];
      assign home = rem_r;
    end
  endgenerate

endmodule
